### sv/lpm_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 longest-prefix-match package
// Shared sizes, route entry layout, request codes, sequencer states and the
// prefix mask helper for the route table block.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int MAX_LEN = 32;
  localparam int ENTRY_W = ADDR_W + LEN_W + ID_WIDTH;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // One stored route
  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [LEN_W-1:0]    len;
    logic [ID_WIDTH-1:0] id;
  } lpm_route_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WRITE  = 4'b0100,
    S_RESULT = 4'b1000
  } lpm_state_t;

  // Mask that keeps the top len bits of an address; len is 0..32, and zero gives an empty mask.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = LEN_W'(MAX_LEN) - len;
    if (len == '0) begin
      return '0;
    end
    return {ADDR_W{1'b1}} << sh;
  endfunction

endpackage

### sv/ipv4_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// IPv4 longest-prefix-match route table
// Stores up to 64 routes and answers longest-prefix lookups by a linear scan.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request per transaction: an insert
//   (req_type 0) with address, prefix length and entry id, or a lookup
//   (req_type 1) with an address. Every request produces exactly one result
//   transaction on the output channel.
//   Each request scans the whole route table through the single read port of
//   the entry RAM, one entry per cycle; an insert with prefix length zero
//   skips the scan and goes straight to its result. The scan sets the
//   throughput: a new request is taken only after the previous result is loaded.
//   in_ready is high only while the sequencer is idle.
//   The result sits in an output register; the next request is accepted
//   while it waits, and the sequencer holds its finished result until the
//   receiver takes the previous one.
//   Reset clears all route valid bits, so the table is empty afterwards;
//   entry contents need no clearing.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_len,
  input  logic [15:0] in_entry_id,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [15:0] out_match_id,
  output logic [5:0]  out_match_len,
  output logic        out_table_full
);

  // Sequencer and scan control
  lpm_pkg::lpm_state_t                state_r, state_nxt;
  logic [lpm_pkg::CNT_W-1:0]          iss_cnt_r;
  logic                               cmp_vld_r;
  logic [lpm_pkg::IDX_W-1:0]          cmp_idx_r;

  // Request held for the duration of the scan
  logic                               req_r;
  logic [lpm_pkg::ADDR_W-1:0]         addr_r;
  logic [lpm_pkg::ADDR_W-1:0]         pfx_r;
  logic [lpm_pkg::LEN_W-1:0]          len_r;
  logic [lpm_pkg::ID_WIDTH-1:0]       id_r;

  // Scan results
  logic                               hit_found_r;
  logic [lpm_pkg::IDX_W-1:0]          hit_idx_r;
  logic                               free_found_r;
  logic [lpm_pkg::IDX_W-1:0]          free_idx_r;
  logic [lpm_pkg::LEN_W-1:0]          best_len_r;
  logic [lpm_pkg::ID_WIDTH-1:0]       best_id_r;

  // Route valid bits
  logic [lpm_pkg::TABLE_DEPTH-1:0]    route_valid_r;

  // Output register
  logic                               out_valid_r;
  logic                               out_found_r;
  logic [15:0]                        out_match_id_r;
  logic [5:0]                         out_match_len_r;
  logic                               out_table_full_r;

  // Datapath signals
  logic [lpm_pkg::LEN_W-1:0]          in_len_sat;
  logic                               issuing;
  logic                               scan_last;
  logic                               out_free;
  lpm_pkg::lpm_route_t                rd_entry;
  lpm_pkg::lpm_route_t                wr_entry;
  logic [lpm_pkg::ENTRY_W-1:0]        rd_data;
  logic                               ent_ok;
  logic                               ins_hit;
  logic                               lkp_hit;
  logic                               wr_en;
  logic [lpm_pkg::IDX_W-1:0]          wr_addr;
  logic                               res_full;

  // Handshake status
  assign in_ready  = (state_r == lpm_pkg::S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign in_len_sat = (in_prefix_len > 6'(lpm_pkg::MAX_LEN)) ?
                      6'(lpm_pkg::MAX_LEN) : in_prefix_len;

  // Scan addressing: one entry read per cycle, compared in the next cycle
  assign issuing   = (state_r == lpm_pkg::S_SCAN) &&
                     (iss_cnt_r != lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH));
  assign scan_last = cmp_vld_r &&
                     (cmp_idx_r == lpm_pkg::IDX_W'(lpm_pkg::TABLE_DEPTH - 1));

  // Table write at the end of an insert scan
  assign wr_en    = (state_r == lpm_pkg::S_WRITE) && (hit_found_r || free_found_r);
  assign wr_addr  = hit_found_r ? hit_idx_r : free_idx_r;
  assign wr_entry = '{prefix: pfx_r, len: len_r, id: id_r};

  lpm_ram #(
    .WIDTH (lpm_pkg::ENTRY_W),
    .DEPTH (lpm_pkg::TABLE_DEPTH)
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (iss_cnt_r[lpm_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Shared compare unit: exact match for inserts, masked match for lookups
  always_comb begin
    rd_entry = rd_data;
    ent_ok   = cmp_vld_r && route_valid_r[cmp_idx_r];
    ins_hit  = ent_ok && (rd_entry.len == len_r) && (rd_entry.prefix == pfx_r);
    lkp_hit  = ent_ok &&
               ((addr_r & lpm_pkg::len_mask(rd_entry.len)) == rd_entry.prefix) &&
               (rd_entry.len > best_len_r);
  end

  // A dropped insert is one with a real length that found neither a slot nor a twin
  assign res_full = (req_r == lpm_pkg::REQ_INSERT) && (len_r != '0) &&
                    !hit_found_r && !free_found_r;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpm_pkg::S_IDLE: begin
        if (in_valid) begin
          if ((in_req_type == lpm_pkg::REQ_INSERT) && (in_len_sat == '0)) begin
            state_nxt = lpm_pkg::S_RESULT;
          end else begin
            state_nxt = lpm_pkg::S_SCAN;
          end
        end
      end
      lpm_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = (req_r == lpm_pkg::REQ_INSERT) ? lpm_pkg::S_WRITE :
                                                       lpm_pkg::S_RESULT;
        end
      end
      lpm_pkg::S_WRITE: begin
        state_nxt = lpm_pkg::S_RESULT;
      end
      lpm_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = lpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lpm_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lpm_pkg::S_IDLE;
      iss_cnt_r     <= '0;
      cmp_vld_r     <= 1'b0;
      route_valid_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= issuing;
      if (in_valid && in_ready) begin
        iss_cnt_r <= '0;
      end else if (issuing) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
      if (wr_en && !hit_found_r) begin
        route_valid_r[free_idx_r] <= 1'b1;
      end
      if ((state_r == lpm_pkg::S_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    cmp_idx_r <= iss_cnt_r[lpm_pkg::IDX_W-1:0];
    if (in_valid && in_ready) begin
      req_r        <= in_req_type;
      addr_r       <= in_address;
      len_r        <= in_len_sat;
      id_r         <= lpm_pkg::ID_WIDTH'(in_entry_id);
      pfx_r        <= in_address & lpm_pkg::len_mask(in_len_sat);
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      best_len_r   <= '0;
      best_id_r    <= '0;
    end else if (state_r == lpm_pkg::S_SCAN) begin
      if (req_r == lpm_pkg::REQ_INSERT) begin
        if (ins_hit && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= cmp_idx_r;
        end
        if (cmp_vld_r && !route_valid_r[cmp_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= cmp_idx_r;
        end
      end else if (lkp_hit) begin
        best_len_r <= rd_entry.len;
        best_id_r  <= rd_entry.id;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state_r == lpm_pkg::S_RESULT) && out_free) begin
      out_found_r      <= (best_len_r != '0);
      out_match_id_r   <= 16'(best_id_r);
      out_match_len_r  <= best_len_r;
      out_table_full_r <= res_full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_match_id   = out_match_id_r;
  assign out_match_len  = out_match_len_r;
  assign out_table_full = out_table_full_r;

endmodule

### sv/lpm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/lpm_checker.sv
// ----------------------------------------------------------------------------
// IPv4 longest-prefix-match port checker
// Watches the ports of the route table and flags inconsistent results.
// ----------------------------------------------------------------------------
module lpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_req_type,
  input logic [31:0] in_address,
  input logic [5:0]  in_prefix_len,
  input logic [15:0] in_entry_id,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [15:0] out_match_id,
  input logic [5:0]  out_match_len,
  input logic        out_table_full
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
    $stable(out_match_id) && $stable(out_match_len) && $stable(out_table_full))
    else $error("result changed while stalled");

  // In the cycle after an accepted request the block is busy and in_ready is low.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on consecutive cycles");

  // A miss reports zero id and length.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_match_id == '0) && (out_match_len == '0))
    else $error("miss with nonzero id or length");

  // A hit carries a real prefix length and never a full flag.
  a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_match_len != '0) && (out_match_len <= 6'd32) &&
    !out_table_full)
    else $error("hit with bad length or full flag");

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (.*);

### verif/tb_ipv4_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// Testbench for the IPv4 longest-prefix-match route table
// Drives insert and lookup transactions through the request channel. A route
// table model inside the testbench predicts every result, and each result
// transaction is compared field by field in order of arrival. A short
// directed table covers empty-table lookups, zero and oversized prefix
// lengths, overwrites and nested prefixes. Random traffic built around a few
// shared networks then fills the table past capacity, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_ipv4_longest_prefix_match;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned HOLD_AT      = 700;
  localparam int unsigned HOLD_CYCLES  = 700;
  localparam int unsigned DRAIN_AT     = 1300;
  localparam int unsigned CALM_FIRST   = 300;
  localparam int unsigned CALM_LAST    = 420;

  // One request as it travels on the input channel.
  typedef struct packed {
    logic                         req_type;
    logic [lpm_pkg::ADDR_W-1:0]   address;
    logic [lpm_pkg::LEN_W-1:0]    prefix_len;
    logic [lpm_pkg::ID_WIDTH-1:0] entry_id;
  } request_t;

  // One result as it travels on the output channel.
  typedef struct packed {
    logic                         found;
    logic [lpm_pkg::ID_WIDTH-1:0] match_id;
    logic [lpm_pkg::LEN_W-1:0]    match_len;
    logic                         table_full;
  } route_result_t;

  // A row of the directed stimulus table.
  typedef struct {
    request_t      rq;
    bit            typed;
    route_result_t want;
  } directed_row_t;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_req_type    = lpm_pkg::REQ_INSERT;
  logic [lpm_pkg::ADDR_W-1:0]   in_address     = '0;
  logic [lpm_pkg::LEN_W-1:0]    in_prefix_len  = '0;
  logic [lpm_pkg::ID_WIDTH-1:0] in_entry_id    = '0;
  logic                         out_ready      = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic                         out_found;
  logic [lpm_pkg::ID_WIDTH-1:0] out_match_id;
  logic [lpm_pkg::LEN_W-1:0]    out_match_len;
  logic                         out_table_full;

  // Testbench copy of the route table.
  logic                right_unused_guard;
  logic                route_live [lpm_pkg::TABLE_DEPTH];
  lpm_pkg::lpm_route_t route_tab  [lpm_pkg::TABLE_DEPTH];
  int                  route_count;

  route_result_t awaited_results[$];
  directed_row_t directed_rows[$];
  logic [lpm_pkg::ADDR_W-1:0] net_base[8];
  int unsigned items_sent;
  int unsigned errors;
  bit          calm_stretch;

  ipv4_longest_prefix_match dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_address    (in_address),
    .in_prefix_len (in_prefix_len),
    .in_entry_id   (in_entry_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_match_id  (out_match_id),
    .out_match_len (out_match_len),
    .out_table_full(out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Network mask that keeps the top len bits; zero length keeps nothing.
  function automatic logic [lpm_pkg::ADDR_W-1:0] prefix_mask(
      input logic [lpm_pkg::LEN_W-1:0] len);
    return ~({lpm_pkg::ADDR_W{1'b1}} >> len);
  endfunction

  function automatic request_t mk_req(input logic t,
                                      input logic [lpm_pkg::ADDR_W-1:0] a,
                                      input logic [lpm_pkg::LEN_W-1:0] l,
                                      input logic [lpm_pkg::ID_WIDTH-1:0] i);
    return {t, a, l, i};
  endfunction

  function automatic route_result_t mk_res(input logic f,
                                           input logic [lpm_pkg::ID_WIDTH-1:0] i,
                                           input logic [lpm_pkg::LEN_W-1:0] l,
                                           input logic full);
    return {f, i, l, full};
  endfunction

  // Apply one request to the table copy and return the result it produces.
  function automatic route_result_t route_table_apply(input request_t rq);
    route_result_t              res;
    logic [lpm_pkg::LEN_W-1:0]  plen;
    logic [lpm_pkg::LEN_W-1:0]  best;
    logic [lpm_pkg::ADDR_W-1:0] pfx;
    int                         slot;
    res  = '0;
    slot = -1;
    best = '0;
    if (rq.req_type == lpm_pkg::REQ_INSERT) begin
      plen = (rq.prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::LEN_W'(lpm_pkg::MAX_LEN) :
                                                  rq.prefix_len;
      if (plen != '0) begin
        pfx = rq.address & prefix_mask(plen);
        // An identical prefix takes the new id, even in a full table.
        for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
          if (slot < 0 && route_live[i] && route_tab[i].len == plen &&
              route_tab[i].prefix == pfx) begin
            slot = i;
          end
        end
        // Otherwise the lowest free slot is claimed.
        for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
          if (slot < 0 && !route_live[i]) begin
            slot          = i;
            route_live[i] = 1'b1;
            route_count++;
          end
        end
        if (slot < 0) begin
          res.table_full = 1'b1;
        end else begin
          route_tab[slot].prefix = pfx;
          route_tab[slot].len    = plen;
          route_tab[slot].id     = rq.entry_id;
        end
      end
    end else begin
      for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
        if (route_live[i] &&
            (rq.address & prefix_mask(route_tab[i].len)) == route_tab[i].prefix &&
            route_tab[i].len > best) begin
          best          = route_tab[i].len;
          res.found     = 1'b1;
          res.match_id  = route_tab[i].id;
          res.match_len = route_tab[i].len;
        end
      end
    end
    return res;
  endfunction

  // Index of a random stored route, or -1 while the table is empty.
  function automatic int pick_live();
    int k;
    if (route_count == 0) begin
      return -1;
    end
    k = $urandom_range(0, route_count - 1);
    for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
      if (route_live[i]) begin
        if (k == 0) begin
          return i;
        end
        k--;
      end
    end
    return -1;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_stretch || r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 120);
  endfunction

  task automatic add_row(input request_t rq, input bit typed, input route_result_t want);
    directed_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Drop valid for a while; with drain set, also wait out every result.
  task automatic pause_input(input int unsigned cycles, input bit drain);
    if (cycles != 0 || drain) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (awaited_results.size() != 0);
      end
    end
  endtask

  // Offer one request transaction and record its expected result on accept.
  task automatic offer(input request_t rq, input bit typed, input route_result_t want);
    route_result_t predicted;
    in_valid      <= 1'b1;
    in_req_type   <= rq.req_type;
    in_address    <= rq.address;
    in_prefix_len <= rq.prefix_len;
    in_entry_id   <= rq.entry_id;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted = route_table_apply(rq);
    awaited_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checking: every result transaction against the oldest expectation.
  always @(posedge clk) begin
    route_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no request outstanding, found %0h id %0h len %0h",
                 $time, out_found, out_match_id, out_match_len);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("found", 32'(want.found), 32'(out_found));
        check_field("match_id", 32'(want.match_id), 32'(out_match_id));
        check_field("match_len", 32'(want.match_len), 32'(out_match_len));
        check_field("table_full", 32'(want.table_full), 32'(out_table_full));
      end
    end
  end

  // Result side ready: random stalls plus one long hold-off that backs up
  // the block until it stops taking requests.
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus: directed table, then random traffic.
  initial begin : stimulus
    request_t      rq;
    int            sel;
    int unsigned   r;
    route_result_t none;

    none         = '0;
    items_sent   = 0;
    errors       = 0;
    calm_stretch = 1'b0;
    route_count  = 0;
    for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
      route_live[i] = 1'b0;
      route_tab[i]  = '0;
    end
    foreach (net_base[k]) begin
      net_base[k] = $urandom;
    end

    // Empty table, zero-length insert, extreme lengths and ids.
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h1234_5678, 6'd0, 16'h1111), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h1234_5678, 6'd0, 16'h0000), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h8000_0000, 6'd1, 16'h0001), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF), 1'b1,
            mk_res(1'b1, 16'hFFFF, 6'd32, 1'b0));
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 6'd0, 16'h0000), 1'b1,
            mk_res(1'b1, 16'h0001, 6'd1, 1'b0));
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 6'd0, 16'h0000), 1'b1, none);
    // Oversized length saturates to a host route; a second one overwrites it.
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h0A0B_0C0D, 6'd63, 16'hAAAA), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0A0B_0C0D, 6'd0, 16'h0000), 1'b1,
            mk_res(1'b1, 16'hAAAA, 6'd32, 1'b0));
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h0A0B_0C0D, 6'd40, 16'h5555), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0A0B_0C0D, 6'd0, 16'h0000), 1'b1,
            mk_res(1'b1, 16'h5555, 6'd32, 1'b0));
    // Nested networks under 10/8.
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h0AFF_FFFF, 6'd8, 16'h0008), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h0A0B_FFFF, 6'd16, 16'h0010), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0A0B_1234, 6'd0, 16'h0000), 1'b0, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0A12_3456, 6'd0, 16'h0000), 1'b0, none);
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h0A0B_0C00, 6'd24, 16'hBEEF), 1'b0, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0A0B_0CFF, 6'd0, 16'h0000), 1'b0, none);
    // Host bits beyond the prefix do not make a new route.
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h80FF_FFFF, 6'd1, 16'h2222), 1'b0, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'hC000_0000, 6'd0, 16'h0000), 1'b0, none);
    // A match with id zero still counts as found.
    add_row(mk_req(lpm_pkg::REQ_INSERT, 32'h0000_0000, 6'd32, 16'h0000), 1'b1, none);
    add_row(mk_req(lpm_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000), 1'b1,
            mk_res(1'b1, 16'h0000, 6'd32, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      pause_input(pick_gap(), 1'b0);
      offer(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
    end

    // Random traffic around a few shared networks so that prefixes nest.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      calm_stretch = (n >= CALM_FIRST && n < CALM_LAST);
      rq.address    = $urandom;
      rq.prefix_len = lpm_pkg::LEN_W'($urandom);
      rq.entry_id   = lpm_pkg::ID_WIDTH'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        rq.req_type = lpm_pkg::REQ_LOOKUP;
        sel = pick_live();
        r   = $urandom_range(0, 9);
        if (sel >= 0 && r < 6) begin
          rq.address = route_tab[sel].prefix |
                       ($urandom & ~prefix_mask(route_tab[sel].len));
        end else if (r < 9) begin
          rq.address = net_base[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 31));
        end
      end else begin
        rq.req_type = lpm_pkg::REQ_INSERT;
        sel = pick_live();
        if (sel >= 0 && $urandom_range(0, 2) == 0) begin
          // Overwrite of a stored route with fresh host bits.
          rq.address    = route_tab[sel].prefix |
                          ($urandom & ~prefix_mask(route_tab[sel].len));
          rq.prefix_len = route_tab[sel].len;
          if (rq.prefix_len == lpm_pkg::MAX_LEN && $urandom_range(0, 1) == 1) begin
            rq.prefix_len = lpm_pkg::LEN_W'($urandom_range(32, 63));
          end
        end else begin
          rq.address = net_base[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 31));
          r = $urandom_range(0, 99);
          if (r < 8) begin
            rq.prefix_len = '0;
          end else if (r < 20) begin
            rq.prefix_len = lpm_pkg::LEN_W'($urandom_range(33, 63));
          end else begin
            rq.prefix_len = lpm_pkg::LEN_W'($urandom_range(1, 32));
          end
        end
      end
      pause_input(pick_gap(), n == DRAIN_AT);
      offer(rq, 1'b0, none);
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
